### hdl/tet10_shape_function_eval_defines.svh
// Assertion macros shared by the tet10 RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef TET10_SHAPE_FUNCTION_EVAL_DEFINES_SVH
`define TET10_SHAPE_FUNCTION_EVAL_DEFINES_SVH

// Condition that holds at every clock edge out of reset
`define TET10_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define TET10_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/tet10_pkg.sv
package tet10_pkg;

  // Field widths
  localparam int COORD_W = 20;  // Q4.16 input
  localparam int RES_W   = 24;  // Q8.16 output
  localparam int IDX_W   = 4;
  localparam int LQ_W    = 30;  // volume coordinate, Q24
  localparam int GRAD_W  = 32;  // gradient constant, Q2.30
  localparam int PROD_W  = 52;  // coordinate times gradient
  localparam int ACC_W   = 53;  // volume coordinate accumulator, Q46
  localparam int OP_W    = 32;  // back-end multiplier operand
  localparam int MUL_W   = 64;  // back-end product
  localparam int SUM_W   = 65;  // derivative sum before rounding

  localparam int NUM_L     = 4;
  localparam int NUM_NODES = 10;
  localparam logic [IDX_W-1:0] NODE_LAST = 4'd9;

  // Gradient constants, Q2.30
  localparam logic signed [GRAD_W-1:0] G_1X  = 32'sd715827883;
  localparam logic signed [GRAD_W-1:0] G_23X = -32'sd357913941;
  localparam logic signed [GRAD_W-1:0] G_3Y  = 32'sd619925131;
  localparam logic signed [GRAD_W-1:0] G_123Z = -32'sd253083375;
  localparam logic signed [GRAD_W-1:0] G_4Z  = 32'sd759250125;

  // [coordinate][axis]
  localparam logic signed [GRAD_W-1:0] GRAD [NUM_L][3] = '{
    '{G_1X,  32'sd0, G_123Z},
    '{G_23X, -G_3Y,  G_123Z},
    '{G_23X, G_3Y,   G_123Z},
    '{32'sd0, 32'sd0, G_4Z}
  };

  // Node order: coordinate pair (a, b), equal for corner nodes
  localparam logic [1:0] NODE_A [NUM_NODES] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2,
                                               2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
  localparam logic [1:0] NODE_B [NUM_NODES] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2,
                                               2'd0, 2'd3, 2'd3, 2'd3, 2'd3};

  // Fixed-point constants
  localparam logic signed [ACC_W-1:0] QUARTER_Q46 = 53'sd1 <<< 44;
  localparam logic signed [ACC_W-1:0] RND_L       = 53'sd1 <<< 21;
  localparam logic signed [OP_W-1:0]  L_ONE       = 32'sd1 <<< 24;
  localparam logic signed [SUM_W-1:0] RND_VAL     = 65'sd1 <<< 31;
  localparam logic signed [SUM_W-1:0] RND_DER     = 65'sd1 <<< 37;
  localparam logic signed [SUM_W-1:0] OUT_MAX     = 65'sd8388607;
  localparam logic signed [SUM_W-1:0] OUT_MIN     = -65'sd8388608;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_xi;
    logic signed [COORD_W-1:0] coord_eta;
    logic signed [COORD_W-1:0] coord_zeta;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        node_index;
    logic signed [RES_W-1:0] shape_value;
    logic signed [RES_W-1:0] deriv_x;
    logic signed [RES_W-1:0] deriv_y;
    logic signed [RES_W-1:0] deriv_z;
    logic                    last_node;
  } out_t;

  // One point's volume coordinates, as queued between front and back
  typedef struct packed {
    logic [NUM_L-1:0][LQ_W-1:0] l;
  } lq_entry_t;

  // Operands of one node, issued into the multiplier stage
  typedef struct packed {
    logic [IDX_W-1:0]       node_index;
    logic                   last_node;
    logic [1:0]             ga_sel;
    logic [1:0]             gb_sel;
    logic signed [OP_W-1:0] val_x;
    logic signed [LQ_W-1:0] val_y;
    logic signed [OP_W-1:0] der_a;
    logic signed [OP_W-1:0] der_b;
  } node_op_t;

  // Clamp to the 24-bit result range
  function automatic logic signed [RES_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
    logic signed [RES_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[RES_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[RES_W-1:0];
    end else begin
      r = v[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

### hdl/tet10_fifo.sv
`include "tet10_shape_function_eval_defines.svh"

module tet10_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Pointer advance with wrap at DEPTH
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign count   = count_r;

  `TET10_ASSERT_IMP(a_no_overflow, wr_en && !rd_en, count_r != CW'(DEPTH), "fifo overflow")
  `TET10_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "fifo count beyond depth")

endmodule

### hdl/tet10_front.sv
module tet10_front
  import tet10_pkg::*;
#(
  parameter int LQ_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_t       in_data,
  input  logic [$clog2(LQ_DEPTH+1)-1:0] lq_count,
  output logic      lq_push,
  output lq_entry_t lq_data
);

  localparam int CW = $clog2(LQ_DEPTH+1);

  logic                     f1_v_r;
  logic signed [PROD_W-1:0] p_1x_r, p_23x_r, p_3y_r, p_123z_r, p_4z_r;
  logic signed [ACC_W-1:0]  acc [NUM_L];
  logic signed [ACC_W-1:0]  rnd [NUM_L];
  logic [CW:0]              used;
  logic                     accept;

  // Room is counted for the point held in the product stage
  assign used   = (CW+1)'(lq_count) + (CW+1)'(f1_v_r);
  assign full   = (used >= (CW+1)'(LQ_DEPTH));
  assign accept = push && !full;

  // Stage 1: the five distinct coordinate-gradient products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_1x_r   <= in_data.coord_xi   * G_1X;
      p_23x_r  <= in_data.coord_xi   * G_23X;
      p_3y_r   <= in_data.coord_eta  * G_3Y;
      p_123z_r <= in_data.coord_zeta * G_123Z;
      p_4z_r   <= in_data.coord_zeta * G_4Z;
    end
  end

  // Stage 2: volume coordinates in Q46, rounded to Q24
  always_comb begin
    acc[0] = QUARTER_Q46 + p_1x_r + p_123z_r;
    acc[1] = QUARTER_Q46 + p_23x_r - p_3y_r + p_123z_r;
    acc[2] = QUARTER_Q46 + p_23x_r + p_3y_r + p_123z_r;
    acc[3] = QUARTER_Q46 + p_4z_r;
    for (int i = 0; i < NUM_L; i++) begin
      rnd[i]       = acc[i] + RND_L;
      lq_data.l[i] = rnd[i][22 +: LQ_W];
    end
  end

  assign lq_push = f1_v_r;

endmodule

### hdl/tet10_back.sv
`include "tet10_shape_function_eval_defines.svh"

module tet10_back
  import tet10_pkg::*;
#(
  parameter int OUT_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lq_entry_t lq_head,
  input  logic      lq_empty,
  output logic      lq_pop,
  input  logic      pop,
  output logic      empty,
  output out_t      out_data
);

  localparam int CW = $clog2(OUT_DEPTH+1);

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             b1_v_r, b2_v_r;
  node_op_t         b1_r, op_nxt;
  logic             issue;
  logic [CW-1:0]    oq_count;
  logic [CW:0]      used;
  logic             oq_empty;
  logic [$bits(out_t)-1:0] oq_rd_data;

  logic signed [LQ_W-1:0] la, lb;
  logic signed [OP_W-1:0] la_ext, lb_ext, la4, lb4;
  logic                   corner;

  logic [IDX_W-1:0]        b2_idx_r;
  logic                    b2_last_r;
  logic signed [MUL_W-1:0] pv_r;
  logic signed [MUL_W-1:0] pa_r [3];
  logic signed [MUL_W-1:0] pb_r [3];

  logic signed [SUM_W-1:0] val_rnd;
  logic signed [SUM_W-1:0] der_rnd [3];
  out_t                    res;

  // Credit: results in flight plus queued never exceed the result queue
  assign used  = (CW+1)'(oq_count) + (CW+1)'(b1_v_r) + (CW+1)'(b2_v_r);
  assign issue = !lq_empty && (used < (CW+1)'(OUT_DEPTH));
  assign lq_pop = issue && (cnt_r == NODE_LAST);

  // Node sequencer: one node of the head point per issue
  always_comb begin
    cnt_nxt = cnt_r;
    if (issue) begin
      cnt_nxt = (cnt_r == NODE_LAST) ? '0 : cnt_r + 1'b1;
    end
  end

  // Operand selection for the current node
  always_comb begin
    la     = $signed(lq_head.l[NODE_A[cnt_r]]);
    lb     = $signed(lq_head.l[NODE_B[cnt_r]]);
    la_ext = OP_W'(la);
    lb_ext = OP_W'(lb);
    la4    = la_ext <<< 2;
    lb4    = lb_ext <<< 2;
    corner = (NODE_A[cnt_r] == NODE_B[cnt_r]);

    op_nxt.node_index = cnt_r;
    op_nxt.last_node  = (cnt_r == NODE_LAST);
    op_nxt.ga_sel     = NODE_A[cnt_r];
    op_nxt.gb_sel     = NODE_B[cnt_r];
    if (corner) begin
      // (2L-1)L and (4L-1)g
      op_nxt.val_x = (la_ext <<< 1) - L_ONE;
      op_nxt.val_y = la;
      op_nxt.der_a = la4 - L_ONE;
      op_nxt.der_b = '0;
    end else begin
      // 4 La Lb and 4 Lb ga + 4 La gb
      op_nxt.val_x = la4;
      op_nxt.val_y = lb;
      op_nxt.der_a = lb4;
      op_nxt.der_b = la4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      b1_v_r <= issue;
      b2_v_r <= b1_v_r;
    end
  end

  // Operand register
  always_ff @(posedge clk) begin
    if (issue) begin
      b1_r <= op_nxt;
    end
  end

  // Multiplier stage
  always_ff @(posedge clk) begin
    if (b1_v_r) begin
      b2_idx_r  <= b1_r.node_index;
      b2_last_r <= b1_r.last_node;
      pv_r      <= b1_r.val_x * b1_r.val_y;
      for (int ax = 0; ax < 3; ax++) begin
        pa_r[ax] <= b1_r.der_a * GRAD[b1_r.ga_sel][ax];
        pb_r[ax] <= b1_r.der_b * GRAD[b1_r.gb_sel][ax];
      end
    end
  end

  // Sum, round to Q16 and saturate
  always_comb begin
    val_rnd = (SUM_W'(pv_r) + RND_VAL) >>> 32;
    for (int ax = 0; ax < 3; ax++) begin
      der_rnd[ax] = (SUM_W'(pa_r[ax]) + SUM_W'(pb_r[ax]) + RND_DER) >>> 38;
    end
    res.node_index  = b2_idx_r;
    res.shape_value = sat24(val_rnd);
    res.deriv_x     = sat24(der_rnd[0]);
    res.deriv_y     = sat24(der_rnd[1]);
    res.deriv_z     = sat24(der_rnd[2]);
    res.last_node   = b2_last_r;
  end

  // Result queue
  tet10_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (b2_v_r),
    .wr_data (res),
    .rd_en   (pop && !oq_empty),
    .rd_data (oq_rd_data),
    .empty   (oq_empty),
    .count   (oq_count)
  );

  assign empty    = oq_empty;
  assign out_data = out_t'(oq_rd_data);

  `TET10_ASSERT_ALWAYS(a_cnt_range, cnt_r <= NODE_LAST, "node counter out of range")
  `TET10_ASSERT_ALWAYS(a_credit, used <= (CW+1)'(OUT_DEPTH), "result credit overrun")

endmodule

### hdl/tet10_shape_function_eval.sv
// Channel   Handshake            Payload   Transaction
// input     push / full          in_data   one point (xi, eta, zeta)
// result    pop / empty          out_data  one node: index, value, gradient
//
// A point yields ten results, one per cycle from the back end's shared
// set of seven multipliers while the coordinate queue holds a point and
// the result queue has credit.
// Reset is synchronous on rst_n, with no clearing pass.
// full rises when LQ_DEPTH points sit in the coordinate queue and front
// stage; the back end stops issuing nodes when its result queue has no credit.
module tet10_shape_function_eval
  import tet10_pkg::*;
#(
  parameter int LQ_DEPTH  = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_data,
  output logic empty,
  input  logic pop,
  output out_t out_data
);

  localparam int LCW = $clog2(LQ_DEPTH+1);

  logic                        lq_push, lq_pop, lq_empty;
  lq_entry_t                   lq_wr_data, lq_head;
  logic [$bits(lq_entry_t)-1:0] lq_rd_data;
  logic [LCW-1:0]              lq_count;

  // Front: accept points, form volume coordinates
  tet10_front #(
    .LQ_DEPTH(LQ_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .lq_count (lq_count),
    .lq_push  (lq_push),
    .lq_data  (lq_wr_data)
  );

  // Coordinate queue between front and back
  tet10_fifo #(
    .WIDTH($bits(lq_entry_t)),
    .DEPTH(LQ_DEPTH)
  ) u_lq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (lq_push),
    .wr_data (lq_wr_data),
    .rd_en   (lq_pop),
    .rd_data (lq_rd_data),
    .empty   (lq_empty),
    .count   (lq_count)
  );

  assign lq_head = lq_entry_t'(lq_rd_data);

  // Back: per-node shape values and derivatives
  tet10_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .lq_head  (lq_head),
    .lq_empty (lq_empty),
    .lq_pop   (lq_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

### sim/tb_tet10_shape_function_eval.sv
`timescale 1ns / 1ps

module tb_tet10_shape_function_eval;
  import tet10_pkg::*;

  localparam int     IDLE_PCT     = 29;
  localparam int     RANDOM_ITEMS = 250;
  localparam longint L_UNIT       = 64'sd1 <<< 24;  // 1.0 in Q24
  localparam longint SAT_HI       = 64'sd8388607;
  localparam longint SAT_LO       = -64'sd8388608;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic push    = 1'b0;
  logic pop     = 1'b0;
  in_t  in_data = '0;
  logic full;
  logic empty;
  out_t out_data;

  in_t  point_queue[$];        // points waiting to be pushed
  out_t node_results_due[$];   // predicted node results, oldest first
  logic in_taken = 1'b0;       // input transaction completed at last rising edge
  int   cyc = 0;
  int   mismatch_count = 0;
  logic calm;

  tet10_shape_function_eval dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // window with no idling on either side
  assign calm = (cyc >= 1200) && (cyc < 2200);

  // volume-coordinate gradients, Q2.30, indexed by coordinate and axis
  function automatic longint grad_q30(input int c, input int ax);
    longint g;
    case (c * 3 + ax)
      0:       g = 715827883;
      2, 5, 8: g = -253083375;
      3, 6:    g = -357913941;
      4:       g = -619925131;
      7:       g = 619925131;
      11:      g = 759250125;
      default: g = 0;
    endcase
    return g;
  endfunction

  // pair of volume coordinates behind each node; equal for corners
  function automatic void node_corners(input int k, output int a, output int b);
    case (k)
      0:       begin a = 0; b = 0; end
      1:       begin a = 0; b = 1; end
      2:       begin a = 1; b = 1; end
      3:       begin a = 1; b = 2; end
      4:       begin a = 2; b = 2; end
      5:       begin a = 2; b = 0; end
      6:       begin a = 0; b = 3; end
      7:       begin a = 1; b = 3; end
      8:       begin a = 2; b = 3; end
      default: begin a = 3; b = 3; end
    endcase
  endfunction

  // round to nearest, ties toward +inf
  function automatic longint round_q(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [RES_W-1:0] clamp24(input longint v);
    longint c;
    c = v;
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    return c[RES_W-1:0];
  endfunction

  // shape values and gradients of all ten nodes at one point
  task automatic predict_nodes(input in_t pt);
    longint crd [3];
    longint vol [NUM_L];
    longint acc, la, lb, shp;
    longint der [3];
    int     a, b;
    out_t   r;
    crd[0] = $signed(pt.coord_xi);
    crd[1] = $signed(pt.coord_eta);
    crd[2] = $signed(pt.coord_zeta);
    for (int i = 0; i < NUM_L; i++) begin
      acc = 64'sd1 <<< 44;
      for (int ax = 0; ax < 3; ax++) acc += crd[ax] * grad_q30(i, ax);
      vol[i] = round_q(acc, 22);
    end
    for (int k = 0; k < NUM_NODES; k++) begin
      node_corners(k, a, b);
      la = vol[a];
      lb = vol[b];
      if (a == b) begin
        shp = (2 * la - L_UNIT) * la;
        for (int ax = 0; ax < 3; ax++) der[ax] = (4 * la - L_UNIT) * grad_q30(a, ax);
      end else begin
        shp = 4 * la * lb;
        for (int ax = 0; ax < 3; ax++)
          der[ax] = 4 * lb * grad_q30(a, ax) + 4 * la * grad_q30(b, ax);
      end
      r.node_index  = k[IDX_W-1:0];
      r.shape_value = clamp24(round_q(shp, 32));
      r.deriv_x     = clamp24(round_q(der[0], 38));
      r.deriv_y     = clamp24(round_q(der[1], 38));
      r.deriv_z     = clamp24(round_q(der[2], 38));
      r.last_node   = (r.node_index == NODE_LAST);
      node_results_due.push_back(r);
    end
  endtask

  task automatic check_field(input string fname, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  function automatic in_t make_point(input int x, input int y, input int z);
    in_t p;
    p.coord_xi   = x[COORD_W-1:0];
    p.coord_eta  = y[COORD_W-1:0];
    p.coord_zeta = z[COORD_W-1:0];
    return p;
  endfunction

  // coordinate drawn from +/- span (Q16)
  function automatic int rand_coord(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // input driver: next point goes out once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!push || in_taken)) begin
      if (point_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_data <= point_queue.pop_front();
        push    <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    pop <= rst_n && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitor: predict on input transaction, check on result transaction
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= push && !full;
      if (push && !full) predict_nodes(in_data);
      if (pop && !empty) begin
        if (node_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got node %0d", $time,
                   out_data.node_index);
        end else begin
          out_t want;
          want = node_results_due.pop_front();
          check_field("node_index", want.node_index, out_data.node_index);
          check_field("shape_value", $signed(want.shape_value), $signed(out_data.shape_value));
          check_field("deriv_x", $signed(want.deriv_x), $signed(out_data.deriv_x));
          check_field("deriv_y", $signed(want.deriv_y), $signed(out_data.deriv_y));
          check_field("deriv_z", $signed(want.deriv_z), $signed(out_data.deriv_z));
          check_field("last_node", want.last_node, out_data.last_node);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int pick;
    // directed: zero, range extremes, sign boundaries, near-vertex points
    point_queue.push_back(make_point(0, 0, 0));
    point_queue.push_back(make_point(524287, 524287, 524287));
    point_queue.push_back(make_point(-524288, -524288, -524288));
    point_queue.push_back(make_point(524287, 0, 0));
    point_queue.push_back(make_point(-524288, 0, 0));
    point_queue.push_back(make_point(0, 524287, 0));
    point_queue.push_back(make_point(0, -524288, 0));
    point_queue.push_back(make_point(0, 0, 524287));
    point_queue.push_back(make_point(0, 0, -524288));
    point_queue.push_back(make_point(1, 1, 1));
    point_queue.push_back(make_point(-1, -1, -1));
    point_queue.push_back(make_point(524287, -524288, 524287));
    point_queue.push_back(make_point(-524288, 524287, -524288));
    point_queue.push_back(make_point('h55555, 'hAAAAA, 'h55555));
    point_queue.push_back(make_point('hAAAAA, 'h55555, 'hAAAAA));
    point_queue.push_back(make_point(65536, 0, -24576));
    point_queue.push_back(make_point(-32768, -56756, -24576));
    point_queue.push_back(make_point(-32768, 56756, -24576));
    point_queue.push_back(make_point(0, 0, 73728));
    point_queue.push_back(make_point(65536, 65536, 65536));
    point_queue.push_back(make_point(-65536, 0, 32768));

    // random: mostly near the element, some wider, some full range
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        point_queue.push_back(make_point(rand_coord(98304), rand_coord(98304),
                                         rand_coord(98304)));
      else if (pick < 90)
        point_queue.push_back(make_point(rand_coord(262144), rand_coord(262144),
                                         rand_coord(262144)));
      else
        point_queue.push_back(make_point($urandom, $urandom, $urandom));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (point_queue.size() != 0 || push) @(posedge clk);
    while (node_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[tet10_shape_function_eval] OK");
    end else begin
      $display("[tet10_shape_function_eval] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("[tet10_shape_function_eval] ERROR");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/tet10_pkg.sv
hdl/tet10_fifo.sv
hdl/tet10_front.sv
hdl/tet10_back.sv
hdl/tet10_shape_function_eval.sv
sim/tb_tet10_shape_function_eval.sv
